// File: rtl/core/humidity_temp_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_macros
// assertion helpers shared by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HTFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("htfd assertion failed");

// antecedent implies consequent in the next cycle
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("htfd assertion failed");

`endif

// File: rtl/core/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// types, constants and crc helper for the humidity/temperature frame decoder
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned TEMP_C_W = 15;
	localparam int unsigned HUM_C_W  = 14;
	localparam int unsigned TEMP_P_W = 31;   // 17500 * 16-bit word
	localparam int unsigned HUM_P_W  = 30;   // 10000 * 16-bit word

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	localparam logic [TEMP_C_W-1:0] TEMP_SPAN   = 15'd17500;
	localparam logic [TEMP_C_W-1:0] TEMP_OFFSET = 15'd4500;
	localparam logic [HUM_C_W-1:0]  HUM_SPAN    = 14'd10000;
	localparam logic [WORD_W:0]     FULL_SCALE  = 17'd65535;

	// byte positions within a reply
	localparam logic [POS_W-1:0] POS_TEMP_MSB = 3'd0;
	localparam logic [POS_W-1:0] POS_TEMP_LSB = 3'd1;
	localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
	localparam logic [POS_W-1:0] POS_HUM_MSB  = 3'd3;
	localparam logic [POS_W-1:0] POS_HUM_LSB  = 3'd4;
	localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_TEMP_CRC = 2'd1,
		STAT_HUM_CRC  = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] temp_word;
		logic [WORD_W-1:0] hum_raw;
		status_t           status;
	} frame_t;

	// one byte through the crc, msb first, no final xor
	function automatic logic [BYTE_W-1:0] crc8_update(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data
	);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/core/htfd_parse.sv
// ----------------------------------------------------------------------------
// htfd_parse
// byte position tracking, word assembly and crc check of one reply
// ----------------------------------------------------------------------------
module htfd_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [htfd_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          frame_start,
	output logic                          frame_done,
	output htfd_pkg::frame_t              frame
);

	logic [htfd_pkg::POS_W-1:0]  pos_q;
	logic [htfd_pkg::BYTE_W-1:0] crc_q;
	logic [htfd_pkg::WORD_W-1:0] temp_q;
	logic [htfd_pkg::WORD_W-1:0] hum_q;
	logic                        temp_bad_q;

	logic [htfd_pkg::POS_W-1:0]  pos;
	logic [htfd_pkg::BYTE_W-1:0] crc_in;
	logic [htfd_pkg::BYTE_W-1:0] crc_next;

	// start flag and out-of-range positions restart at the first byte
	always_comb begin
		if (frame_start || (pos_q > htfd_pkg::POS_HUM_CRC)) begin
			pos = htfd_pkg::POS_TEMP_MSB;
		end else begin
			pos = pos_q;
		end
	end

	assign crc_in   = ((pos == htfd_pkg::POS_TEMP_MSB) || (pos == htfd_pkg::POS_HUM_MSB)) ?
	                  htfd_pkg::CRC_INIT : crc_q;
	assign crc_next = htfd_pkg::crc8_update(crc_in, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= htfd_pkg::POS_TEMP_MSB;
			crc_q      <= htfd_pkg::CRC_INIT;
			temp_q     <= '0;
			hum_q      <= '0;
			temp_bad_q <= 1'b0;
		end else if (take) begin
			unique case (pos)
				htfd_pkg::POS_TEMP_MSB: begin
					temp_q <= {data_byte, 8'h00};
					crc_q  <= crc_next;
				end
				htfd_pkg::POS_TEMP_LSB: begin
					temp_q[htfd_pkg::BYTE_W-1:0] <= data_byte;
					crc_q                        <= crc_next;
				end
				htfd_pkg::POS_TEMP_CRC: begin
					temp_bad_q <= (crc_q != data_byte);
				end
				htfd_pkg::POS_HUM_MSB: begin
					hum_q <= {data_byte, 8'h00};
					crc_q <= crc_next;
				end
				htfd_pkg::POS_HUM_LSB: begin
					hum_q[htfd_pkg::BYTE_W-1:0] <= data_byte;
					crc_q                       <= crc_next;
				end
				default: begin
				end
			endcase
			pos_q <= (pos == htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_MSB : pos + 3'd1;
		end
	end

	assign frame_done = take && (pos == htfd_pkg::POS_HUM_CRC);

	always_comb begin
		frame.temp_word = temp_q;
		frame.hum_raw   = hum_q;
		priority if (temp_bad_q) begin
			frame.status = htfd_pkg::STAT_TEMP_CRC;
		end else if (crc_q != data_byte) begin
			frame.status = htfd_pkg::STAT_HUM_CRC;
		end else begin
			frame.status = htfd_pkg::STAT_OK;
		end
	end

endmodule

// File: rtl/core/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// six-byte sensor reply decoder with crc-8 check and fixed-point conversion
// ----------------------------------------------------------------------------
// Takes one reply byte per cycle on the slave stream while s_axis_tready is
// high (tuser marks the first byte of a reply) and emits one item on the
// master stream after every sixth byte: temperature in 1/100 degC, humidity
// in 1/100 %RH, both raw words and a status (0 ok, 1 temperature crc bad, 2
// humidity crc bad; converted values read 0 on a crc error). The frame of a
// reply is loaded into the frame register at the clock edge that takes its
// last byte and then passes through the multiplier register and the output
// register, whose valid flag drives m_axis_tvalid. Input stays open while a
// result waits, until all three stages hold results.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_macros.svh"

module humidity_temp_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
	                                    // [44:29] temperature_raw, [60:45] humidity_raw, zero pad
	output logic [1:0]  m_axis_tuser    // [1:0] frame_status
);

	logic             take;
	logic             frame_done;
	htfd_pkg::frame_t frame;

	logic             v_s1;
	htfd_pkg::frame_t frame_s1;

	logic                          v_s2;
	htfd_pkg::frame_t              frame_s2;
	logic [htfd_pkg::TEMP_P_W-1:0] temp_prod_s2;
	logic [htfd_pkg::HUM_P_W-1:0]  hum_prod_s2;

	logic                          out_valid_q;
	logic [htfd_pkg::TEMP_C_W-1:0] temp_centi_q;
	logic [htfd_pkg::HUM_C_W-1:0]  hum_centi_q;
	logic [htfd_pkg::WORD_W-1:0]   temp_word_q;
	logic [htfd_pkg::WORD_W-1:0]   hum_raw_q;
	htfd_pkg::status_t             status_q;

	logic out_ready;
	logic adv_s2;
	logic adv_s1;

	logic [htfd_pkg::TEMP_C_W-1:0] temp_hi;
	logic [htfd_pkg::HUM_C_W-1:0]  hum_hi;
	logic [htfd_pkg::WORD_W:0]     temp_sum;
	logic [htfd_pkg::WORD_W:0]     hum_sum;
	logic [htfd_pkg::TEMP_C_W-1:0] temp_quot;
	logic [htfd_pkg::HUM_C_W-1:0]  hum_quot;
	logic [htfd_pkg::TEMP_C_W-1:0] temp_centi;
	logic [htfd_pkg::HUM_C_W-1:0]  hum_centi;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign adv_s2        = !v_s2 || out_ready;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign take          = s_axis_tvalid && s_axis_tready;

	htfd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.frame_done  (frame_done),
		.frame       (frame)
	);

	// x / 65535 = hi + ((hi + lo) >= 65535) where x = hi * 2^16 + lo
	assign temp_hi   = temp_prod_s2[htfd_pkg::TEMP_P_W-1:htfd_pkg::WORD_W];
	assign hum_hi    = hum_prod_s2[htfd_pkg::HUM_P_W-1:htfd_pkg::WORD_W];
	assign temp_sum  = 17'(temp_hi) + 17'(temp_prod_s2[htfd_pkg::WORD_W-1:0]);
	assign hum_sum   = 17'(hum_hi) + 17'(hum_prod_s2[htfd_pkg::WORD_W-1:0]);
	assign temp_quot = temp_hi + 15'(temp_sum >= htfd_pkg::FULL_SCALE);
	assign hum_quot  = hum_hi + 14'(hum_sum >= htfd_pkg::FULL_SCALE);

	always_comb begin
		if (frame_s2.status == htfd_pkg::STAT_OK) begin
			temp_centi = temp_quot - htfd_pkg::TEMP_OFFSET;
			hum_centi  = hum_quot;
		end else begin
			temp_centi = '0;
			hum_centi  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= frame_done;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (out_ready) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && frame_done) begin
			frame_s1 <= frame;
		end
		if (adv_s2 && v_s1) begin
			frame_s2     <= frame_s1;
			temp_prod_s2 <= 31'(frame_s1.temp_word) * 31'(htfd_pkg::TEMP_SPAN);
			hum_prod_s2  <= 30'(frame_s1.hum_raw) * 30'(htfd_pkg::HUM_SPAN);
		end
		if (out_ready && v_s2) begin
			temp_centi_q <= temp_centi;
			hum_centi_q  <= hum_centi;
			temp_word_q  <= frame_s2.temp_word;
			hum_raw_q    <= frame_s2.hum_raw;
			status_q     <= frame_s2.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, hum_raw_q, temp_word_q, hum_centi_q, temp_centi_q};
	assign m_axis_tuser  = status_q;

	`HTFD_ASSERT_SAME(a_err_zero, clk, arst_n,
		out_valid_q && (status_q != htfd_pkg::STAT_OK),
		(temp_centi_q == '0) && (hum_centi_q == '0))
	`HTFD_ASSERT_SAME(a_hum_range, clk, arst_n, out_valid_q,
		hum_centi_q <= htfd_pkg::HUM_SPAN)
	`HTFD_ASSERT_SAME(a_temp_range, clk, arst_n, out_valid_q,
		($signed(temp_centi_q) >= -15'sd4500) && ($signed(temp_centi_q) <= 15'sd13000))
	`HTFD_ASSERT_SAME(a_open_when_empty, clk, arst_n, !v_s1, s_axis_tready)
	`HTFD_ASSERT_NEXT(a_s1_holds, clk, arst_n, v_s1 && !adv_s2, v_s1 && $stable(frame_s1))

endmodule
